// ----- rtl/core/pal_pkg.sv -----
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types, codes and defaults of the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

	localparam int DEPTH_DEFAULT      = 128;
	localparam int DATA_WIDTH_DEFAULT = 32;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_DELETE = 3'd1;
	localparam logic [2:0] CMD_SET    = 3'd2;
	localparam logic [2:0] CMD_GET    = 3'd3;
	localparam logic [2:0] CMD_LOCATE = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ILLEGAL = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  position;
		logic [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [6:0]  found_index;
		logic        found;
		logic [1:0]  status;
		logic [7:0]  list_length;
		logic        list_empty;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_INS_RD,
		S_INS_WR,
		S_INS_LAST,
		S_GET_CAP,
		S_DEL_CAP,
		S_DEL_RD,
		S_DEL_WR,
		S_DEL_LAST,
		S_LOC_CMP,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_COUNT,
		PTR_POS,
		PTR_ZERO,
		PTR_DEC,
		PTR_INC
	} ptr_op_t;

	typedef enum logic [1:0] {
		RA_POS,
		RA_PTR_DEC,
		RA_PTR_INC,
		RA_ZERO
	} rd_sel_t;

	typedef enum logic {
		WA_PTR_DATA,
		WA_POS_VAL
	} wr_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef struct packed {
		logic       req_load;
		ptr_op_t    ptr_op;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       wr_en;
		wr_sel_t    wr_sel;
		cnt_op_t    cnt_op;
		logic       st_set;
		logic [1:0] st_val;
		logic       rd_cap;
		logic       found_cap;
		logic       out_load;
	} ctl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       pos_gt_cnt;
		logic       pos_ge_cnt;
		logic       pos_eq_cnt;
		logic       full;
		logic       cnt_zero;
		logic       ptr_eq_pos1;
		logic       pos1_lt_cnt;
		logic       ptr2_lt_cnt;
		logic       ptr1_ge_cnt;
		logic       match;
		logic       out_free;
	} stat_t;

endpackage

// ----- rtl/core/pal_ctrl.sv -----
// ----------------------------------------------------------------------------
// pal_ctrl
// Sequencer of the positional array list: decodes each request and steps the
// datapath through entry moves, scans and the result hand-off.
// ----------------------------------------------------------------------------
module pal_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pal_pkg::stat_t stat,
	output pal_pkg::ctl_t  ctl
);
	import pal_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_DONE;
				unique case (stat.cmd)
					CMD_INSERT: begin
						if (!stat.pos_gt_cnt && !stat.full) begin
							state_d = stat.pos_eq_cnt ? S_INS_LAST : S_INS_RD;
						end
					end
					CMD_DELETE: begin
						if (!stat.pos_ge_cnt) state_d = S_DEL_CAP;
					end
					CMD_GET: begin
						if (!stat.pos_ge_cnt) state_d = S_GET_CAP;
					end
					CMD_LOCATE: begin
						if (!stat.cnt_zero) state_d = S_LOC_CMP;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_INS_RD:   state_d = S_INS_WR;
			S_INS_WR:   state_d = stat.ptr_eq_pos1 ? S_INS_LAST : S_INS_RD;
			S_INS_LAST: state_d = S_DONE;
			S_GET_CAP:  state_d = S_DONE;
			S_DEL_CAP:  state_d = stat.pos1_lt_cnt ? S_DEL_RD : S_DEL_LAST;
			S_DEL_RD:   state_d = S_DEL_WR;
			S_DEL_WR:   state_d = stat.ptr2_lt_cnt ? S_DEL_RD : S_DEL_LAST;
			S_DEL_LAST: state_d = S_DONE;
			S_LOC_CMP: begin
				if (stat.match || stat.ptr1_ge_cnt) state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		req_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				ctl.req_load = req_valid;
			end
			S_EXEC: begin
				unique case (stat.cmd)
					CMD_INSERT: begin
						priority if (stat.pos_gt_cnt) begin
							ctl.st_set = 1'b1;
							ctl.st_val = ST_ILLEGAL;
						end else if (stat.full) begin
							ctl.st_set = 1'b1;
							ctl.st_val = ST_FULL;
						end else begin
							ctl.ptr_op = PTR_COUNT;
						end
					end
					CMD_DELETE, CMD_GET: begin
						if (stat.pos_ge_cnt) begin
							ctl.st_set = 1'b1;
							ctl.st_val = ST_ILLEGAL;
						end else begin
							ctl.rd_en  = 1'b1;
							ctl.rd_sel = RA_POS;
						end
					end
					CMD_SET: begin
						if (stat.pos_ge_cnt) begin
							ctl.st_set = 1'b1;
							ctl.st_val = ST_ILLEGAL;
						end else begin
							ctl.wr_en  = 1'b1;
							ctl.wr_sel = WA_POS_VAL;
						end
					end
					CMD_LOCATE: begin
						if (!stat.cnt_zero) begin
							ctl.rd_en  = 1'b1;
							ctl.rd_sel = RA_ZERO;
							ctl.ptr_op = PTR_ZERO;
						end
					end
					default: ;
				endcase
			end
			S_INS_RD: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = RA_PTR_DEC;
			end
			S_INS_WR: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = WA_PTR_DATA;
				ctl.ptr_op = PTR_DEC;
			end
			S_INS_LAST: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = WA_POS_VAL;
				ctl.cnt_op = CNT_INC;
			end
			S_GET_CAP: begin
				ctl.rd_cap = 1'b1;
			end
			S_DEL_CAP: begin
				ctl.rd_cap = 1'b1;
				ctl.ptr_op = PTR_POS;
			end
			S_DEL_RD: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = RA_PTR_INC;
			end
			S_DEL_WR: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_sel = WA_PTR_DATA;
				ctl.ptr_op = PTR_INC;
			end
			S_DEL_LAST: begin
				ctl.cnt_op = CNT_DEC;
			end
			S_LOC_CMP: begin
				priority if (stat.match) begin
					ctl.found_cap = 1'b1;
				end else if (!stat.ptr1_ge_cnt) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RA_PTR_INC;
					ctl.ptr_op = PTR_INC;
				end else begin
					ctl.ptr_op = PTR_HOLD;
				end
			end
			S_DONE: begin
				ctl.out_load = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/core/pal_dp.sv -----
// ----------------------------------------------------------------------------
// pal_dp
// Datapath of the positional array list: entry memory, length counter, scan
// pointer, request and result registers, and the response output register.
// ----------------------------------------------------------------------------
module pal_dp #(
	parameter int DEPTH      = pal_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pal_pkg::req_t  req,
	input  pal_pkg::ctl_t  ctl,
	output pal_pkg::stat_t stat,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pal_pkg::rsp_t  rsp
);
	import pal_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int EW = ((CW > 8) ? CW : 8) + 2;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic [2:0]            cmd_q;
	logic [7:0]            pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         ptr_q;

	logic [DATA_WIDTH-1:0] res_rd_q;
	logic [CW-1:0]         res_fidx_q;
	logic                  res_found_q;
	logic [1:0]            res_st_q;

	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [EW-1:0]         pos_e;
	logic [EW-1:0]         cnt_e;
	logic [EW-1:0]         ptr_e;
	logic [AW-1:0]         raddr;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;

	assign pos_e = EW'(pos_q);
	assign cnt_e = EW'(count_q);
	assign ptr_e = EW'(ptr_q);

	always_comb begin
		stat.cmd         = cmd_q;
		stat.pos_gt_cnt  = pos_e > cnt_e;
		stat.pos_ge_cnt  = pos_e >= cnt_e;
		stat.pos_eq_cnt  = pos_e == cnt_e;
		stat.full        = cnt_e >= EW'(DEPTH);
		stat.cnt_zero    = count_q == '0;
		stat.ptr_eq_pos1 = ptr_e == pos_e + EW'(1);
		stat.pos1_lt_cnt = pos_e + EW'(1) < cnt_e;
		stat.ptr2_lt_cnt = ptr_e + EW'(2) < cnt_e;
		stat.ptr1_ge_cnt = ptr_e + EW'(1) >= cnt_e;
		stat.match       = rdata_q == val_q;
		stat.out_free    = !rsp_valid_q || !rsp_stall;
	end

	always_comb begin
		unique case (ctl.rd_sel)
			RA_POS:     raddr = AW'(pos_q);
			RA_PTR_DEC: raddr = AW'(ptr_q - CW'(1));
			RA_PTR_INC: raddr = AW'(ptr_q + CW'(1));
			RA_ZERO:    raddr = '0;
			default:    raddr = '0;
		endcase
	end

	always_comb begin
		unique case (ctl.wr_sel)
			WA_PTR_DATA: begin
				waddr = AW'(ptr_q);
				wdata = rdata_q;
			end
			WA_POS_VAL: begin
				waddr = AW'(pos_q);
				wdata = val_q;
			end
			default: begin
				waddr = AW'(pos_q);
				wdata = val_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.req_load) begin
			cmd_q <= req.command;
			pos_q <= req.position;
			val_q <= DATA_WIDTH'(req.item_value);
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.ptr_op)
			PTR_HOLD:  ptr_q <= ptr_q;
			PTR_COUNT: ptr_q <= count_q;
			PTR_POS:   ptr_q <= CW'(pos_q);
			PTR_ZERO:  ptr_q <= '0;
			PTR_DEC:   ptr_q <= ptr_q - CW'(1);
			PTR_INC:   ptr_q <= ptr_q + CW'(1);
			default:   ptr_q <= ptr_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (ctl.cnt_op)
				CNT_HOLD: count_q <= count_q;
				CNT_INC:  count_q <= count_q + CW'(1);
				CNT_DEC:  count_q <= count_q - CW'(1);
				default:  count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.req_load) begin
			res_rd_q    <= '0;
			res_fidx_q  <= '0;
			res_found_q <= 1'b0;
			res_st_q    <= ST_OK;
		end else begin
			if (ctl.st_set) res_st_q <= ctl.st_val;
			if (ctl.rd_cap) res_rd_q <= rdata_q;
			if (ctl.found_cap) begin
				res_found_q <= 1'b1;
				res_fidx_q  <= ptr_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			rsp_q.read_value  <= 32'(res_rd_q);
			rsp_q.found_index <= 7'(res_fidx_q);
			rsp_q.found       <= res_found_q;
			rsp_q.status      <= res_st_q;
			rsp_q.list_length <= 8'(count_q);
			rsp_q.list_empty  <= count_q == '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		EW'(count_q) <= EW'(DEPTH))
		else $error("list length exceeds depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1))))
		else $error("list length moved by more than one");

	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.found_cap |-> (ptr_q < count_q))
		else $error("locate hit beyond list length");

	a_move_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.wr_en && (ctl.wr_sel == WA_PTR_DATA)) |-> (ptr_q <= count_q))
		else $error("entry move beyond list length");

endmodule

// ----- rtl/core/positional_array_list.sv -----
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of up to DEPTH entries kept packed from position zero, with
// insert, delete, set, get and locate requests over a valid/stall interface.
// ----------------------------------------------------------------------------
// One request is handled at a time and each produces exactly one response
// transaction. The entries live in a single memory with one write and one
// registered read port: a rejected request only sets its status, set writes
// its entry, get reads and captures it, locate compares the entries from
// position zero until a match or the end, insert moves each entry from the
// end down to the position up by one before writing the new value, and delete
// captures its entry and moves each later entry down by one. A finished
// response waits in an output register, so the next request is taken as soon
// as the response has been loaded there.
module positional_array_list #(
	parameter int DEPTH      = pal_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pal_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pal_pkg::rsp_t rsp
);
	import pal_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	pal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	pal_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctl       (ctl),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
